FILE: hdl/i2c_master_transaction_sequencer_top_macros.svh
// Assertion macros for the I2C master transaction sequencer.
// Included by the top level; needs clock and reset in the including scope.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_TOP_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define I2CMTS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sequencer check failed");

// next-cycle implication
`define I2CMTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sequencer check failed");

`endif

FILE: hdl/i2cmts_pkg.sv
// Shared types and codes for the I2C master transaction sequencer.
// No dependencies; used by every module of the block.
`default_nettype none
package i2cmts_pkg;

   localparam int unsigned MAX_TRANSFER_DEF = 255;
   localparam logic [15:0] TIMEOUT_RESET    = 16'd50000;

   localparam logic [6:0] ADDR_LOW  = 7'h08;
   localparam logic [6:0] ADDR_HIGH = 7'h77;

   localparam logic [7:0] STATUS_MASK    = 8'hF8;
   localparam logic [7:0] ES_BUS_ERROR   = 8'h00;
   localparam logic [7:0] ES_START       = 8'h08;
   localparam logic [7:0] ES_AW_ACK      = 8'h18;
   localparam logic [7:0] ES_AW_NACK     = 8'h20;
   localparam logic [7:0] ES_DW_ACK      = 8'h28;
   localparam logic [7:0] ES_DW_NACK     = 8'h30;
   localparam logic [7:0] ES_ARB_LOST    = 8'h38;
   localparam logic [7:0] ES_AR_ACK      = 8'h40;
   localparam logic [7:0] ES_AR_NACK     = 8'h48;
   localparam logic [7:0] ES_DR_ACK      = 8'h50;
   localparam logic [7:0] ES_DR_NACK     = 8'h58;

   typedef enum logic [2:0] {
      OP_BEGIN     = 3'd0,
      OP_WRITE     = 3'd1,
      OP_STATUS    = 3'd2,
      OP_TICK      = 3'd3,
      OP_STOP_DONE = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_START = 3'd1,
      PH_ADDR  = 3'd2,
      PH_NEED  = 3'd3,
      PH_WRITE = 3'd4,
      PH_READ  = 3'd5,
      PH_STOP  = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_SEND    = 3'd2,
      CMD_RX_ACK  = 3'd3,
      CMD_RX_NACK = 3'd4,
      CMD_STOP    = 3'd5
   } cmd_type;

   typedef enum logic [3:0] {
      ST_OK      = 4'd0,
      ST_TIMEOUT = 4'd1,
      ST_ARB     = 4'd2,
      ST_BUS     = 4'd3,
      ST_STARTF  = 4'd4,
      ST_STOPF   = 4'd5,
      ST_ANACK   = 4'd6,
      ST_DNACK   = 4'd7,
      ST_RXF     = 4'd8,
      ST_BADADDR = 4'd9,
      ST_BADARG  = 4'd10
   } status_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [6:0] target_address;
      logic       read_not_write;
      logic [7:0] byte_count;
      logic [7:0] write_byte;
      logic [7:0] engine_status;
      logic [7:0] engine_data;
   } item_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] command_byte;
      logic       need_write_data;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       done_res;
      logic [3:0] status;
      logic       busy_res;
   } result_type;

endpackage
`default_nettype wire

FILE: hdl/i2cmts_in_stage.sv
// Input register of the sequencer: captures one request beat.
// Depends on i2cmts_pkg.
`default_nettype none
module i2cmts_in_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire i2cmts_pkg::item_type in_item,
   input  wire logic                 advance,
   output logic                      item_valid,
   output i2cmts_pkg::item_type      item
);

   logic                 valid_ff;
   logic                 valid_in;
   i2cmts_pkg::item_type item_ff;

   assign in_ready   = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/i2cmts_core.sv
// Transaction state and phase logic of the sequencer, plus the timeout register.
// Depends on i2cmts_pkg.
`default_nettype none
module i2cmts_core #(
   parameter int unsigned MAX_TRANSFER = i2cmts_pkg::MAX_TRANSFER_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [15:0]          csr_wr_data,
   input  wire logic                 advance,
   input  wire i2cmts_pkg::item_type item,
   output i2cmts_pkg::result_type    result
);

   i2cmts_pkg::phase_type phase_ff, phase_in;
   logic [6:0]  slave_address_ff, slave_address_in;
   logic        direction_read_ff, direction_read_in;
   logic [7:0]  bytes_total_ff, bytes_total_in;
   logic [7:0]  bytes_done_ff, bytes_done_in;
   logic [3:0]  pending_status_ff, pending_status_in;
   logic [15:0] wait_ticks_ff, wait_ticks_in;
   logic [15:0] timeout_limit_ff;

   logic [7:0]  es;
   logic [7:0]  done_inc;
   logic        last_rx;
   logic        last_next;
   logic [15:0] ticks_sat;

   assign es        = item.engine_status & i2cmts_pkg::STATUS_MASK;
   assign done_inc  = bytes_done_ff + 8'd1;
   assign last_rx   = ({1'b0, bytes_done_ff} + 9'd1) >= {1'b0, bytes_total_ff};
   assign last_next = ({1'b0, done_inc} + 9'd1) >= {1'b0, bytes_total_ff};
   assign ticks_sat = (wait_ticks_ff == 16'hFFFF) ? wait_ticks_ff : wait_ticks_ff + 16'd1;

   always_comb begin
      phase_in          = phase_ff;
      slave_address_in  = slave_address_ff;
      direction_read_in = direction_read_ff;
      bytes_total_in    = bytes_total_ff;
      bytes_done_in     = bytes_done_ff;
      pending_status_in = pending_status_ff;
      wait_ticks_in     = wait_ticks_ff;
      result            = '0;

      case (item.operation)
         i2cmts_pkg::OP_BEGIN: begin
            if (phase_ff == i2cmts_pkg::PH_IDLE) begin
               if (item.target_address < i2cmts_pkg::ADDR_LOW ||
                   item.target_address > i2cmts_pkg::ADDR_HIGH) begin
                  result.done_res = 1'b1;
                  result.status   = i2cmts_pkg::ST_BADADDR;
               end else if ((item.read_not_write && item.byte_count == 8'd0) ||
                            {8'd0, item.byte_count} > 16'(MAX_TRANSFER)) begin
                  result.done_res = 1'b1;
                  result.status   = i2cmts_pkg::ST_BADARG;
               end else begin
                  slave_address_in  = item.target_address;
                  direction_read_in = item.read_not_write;
                  bytes_total_in    = item.byte_count;
                  bytes_done_in     = 8'd0;
                  pending_status_in = i2cmts_pkg::ST_OK;
                  result.command    = i2cmts_pkg::CMD_START;
                  phase_in          = i2cmts_pkg::PH_START;
                  wait_ticks_in     = 16'd0;
               end
            end
         end
         i2cmts_pkg::OP_WRITE: begin
            if (phase_ff == i2cmts_pkg::PH_NEED) begin
               result.command      = i2cmts_pkg::CMD_SEND;
               result.command_byte = item.write_byte;
               phase_in            = i2cmts_pkg::PH_WRITE;
               wait_ticks_in       = 16'd0;
            end
         end
         i2cmts_pkg::OP_STATUS: begin
            unique case (phase_ff)
               i2cmts_pkg::PH_START: begin
                  if (es == i2cmts_pkg::ES_START) begin
                     result.command      = i2cmts_pkg::CMD_SEND;
                     result.command_byte = {slave_address_ff, direction_read_ff};
                     phase_in            = i2cmts_pkg::PH_ADDR;
                     wait_ticks_in       = 16'd0;
                  end else begin
                     result.done_res = 1'b1;
                     phase_in        = i2cmts_pkg::PH_IDLE;
                     if (es == i2cmts_pkg::ES_ARB_LOST) begin
                        result.status = i2cmts_pkg::ST_ARB;
                     end else if (es == i2cmts_pkg::ES_BUS_ERROR) begin
                        result.status = i2cmts_pkg::ST_BUS;
                     end else begin
                        result.status = i2cmts_pkg::ST_STARTF;
                     end
                  end
               end
               i2cmts_pkg::PH_ADDR: begin
                  if (es == (direction_read_ff ? i2cmts_pkg::ES_AR_ACK
                                               : i2cmts_pkg::ES_AW_ACK)) begin
                     if (direction_read_ff) begin
                        result.command = last_rx ? i2cmts_pkg::CMD_RX_NACK
                                                 : i2cmts_pkg::CMD_RX_ACK;
                        phase_in       = i2cmts_pkg::PH_READ;
                        wait_ticks_in  = 16'd0;
                     end else if (bytes_total_ff == 8'd0) begin
                        pending_status_in = i2cmts_pkg::ST_OK;
                        result.command    = i2cmts_pkg::CMD_STOP;
                        phase_in          = i2cmts_pkg::PH_STOP;
                        wait_ticks_in     = 16'd0;
                     end else begin
                        phase_in               = i2cmts_pkg::PH_NEED;
                        result.need_write_data = 1'b1;
                     end
                  end else if (es == (direction_read_ff ? i2cmts_pkg::ES_AR_NACK
                                                        : i2cmts_pkg::ES_AW_NACK)) begin
                     pending_status_in = i2cmts_pkg::ST_ANACK;
                     result.command    = i2cmts_pkg::CMD_STOP;
                     phase_in          = i2cmts_pkg::PH_STOP;
                     wait_ticks_in     = 16'd0;
                  end else begin
                     result.done_res = 1'b1;
                     phase_in        = i2cmts_pkg::PH_IDLE;
                     result.status   = (es == i2cmts_pkg::ES_ARB_LOST) ?
                                       i2cmts_pkg::ST_ARB : i2cmts_pkg::ST_BUS;
                  end
               end
               i2cmts_pkg::PH_WRITE: begin
                  if (es == i2cmts_pkg::ES_DW_ACK) begin
                     bytes_done_in = done_inc;
                     if (done_inc >= bytes_total_ff) begin
                        pending_status_in = i2cmts_pkg::ST_OK;
                        result.command    = i2cmts_pkg::CMD_STOP;
                        phase_in          = i2cmts_pkg::PH_STOP;
                        wait_ticks_in     = 16'd0;
                     end else begin
                        phase_in               = i2cmts_pkg::PH_NEED;
                        result.need_write_data = 1'b1;
                     end
                  end else if (es == i2cmts_pkg::ES_DW_NACK) begin
                     pending_status_in = i2cmts_pkg::ST_DNACK;
                     result.command    = i2cmts_pkg::CMD_STOP;
                     phase_in          = i2cmts_pkg::PH_STOP;
                     wait_ticks_in     = 16'd0;
                  end else begin
                     result.done_res = 1'b1;
                     phase_in        = i2cmts_pkg::PH_IDLE;
                     result.status   = (es == i2cmts_pkg::ES_ARB_LOST) ?
                                       i2cmts_pkg::ST_ARB : i2cmts_pkg::ST_BUS;
                  end
               end
               i2cmts_pkg::PH_READ: begin
                  if (es == (last_rx ? i2cmts_pkg::ES_DR_NACK : i2cmts_pkg::ES_DR_ACK)) begin
                     result.read_valid = 1'b1;
                     result.read_byte  = item.engine_data;
                     bytes_done_in     = done_inc;
                     wait_ticks_in     = 16'd0;
                     if (last_rx) begin
                        pending_status_in = i2cmts_pkg::ST_OK;
                        result.command    = i2cmts_pkg::CMD_STOP;
                        phase_in          = i2cmts_pkg::PH_STOP;
                     end else begin
                        result.command = last_next ? i2cmts_pkg::CMD_RX_NACK
                                                   : i2cmts_pkg::CMD_RX_ACK;
                        phase_in       = i2cmts_pkg::PH_READ;
                     end
                  end else if (es == i2cmts_pkg::ES_ARB_LOST || es == i2cmts_pkg::ES_BUS_ERROR) begin
                     result.done_res = 1'b1;
                     phase_in        = i2cmts_pkg::PH_IDLE;
                     result.status   = (es == i2cmts_pkg::ES_ARB_LOST) ?
                                       i2cmts_pkg::ST_ARB : i2cmts_pkg::ST_BUS;
                  end else begin
                     pending_status_in = i2cmts_pkg::ST_RXF;
                     result.command    = i2cmts_pkg::CMD_STOP;
                     phase_in          = i2cmts_pkg::PH_STOP;
                     wait_ticks_in     = 16'd0;
                  end
               end
               default: begin
               end
            endcase
         end
         i2cmts_pkg::OP_TICK: begin
            if (phase_ff == i2cmts_pkg::PH_START || phase_ff == i2cmts_pkg::PH_ADDR ||
                phase_ff == i2cmts_pkg::PH_WRITE || phase_ff == i2cmts_pkg::PH_READ ||
                phase_ff == i2cmts_pkg::PH_STOP) begin
               wait_ticks_in = ticks_sat;
               if (ticks_sat >= timeout_limit_ff) begin
                  result.done_res = 1'b1;
                  phase_in        = i2cmts_pkg::PH_IDLE;
                  result.status   = (phase_ff == i2cmts_pkg::PH_STOP) ?
                                    i2cmts_pkg::ST_STOPF : i2cmts_pkg::ST_TIMEOUT;
               end
            end
         end
         i2cmts_pkg::OP_STOP_DONE: begin
            if (phase_ff == i2cmts_pkg::PH_STOP) begin
               result.done_res = 1'b1;
               result.status   = pending_status_ff;
               phase_in        = i2cmts_pkg::PH_IDLE;
            end
         end
         default: begin
         end
      endcase

      result.busy_res = (phase_in != i2cmts_pkg::PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= i2cmts_pkg::PH_IDLE;
         slave_address_ff  <= 7'd0;
         direction_read_ff <= 1'b0;
         bytes_total_ff    <= 8'd0;
         bytes_done_ff     <= 8'd0;
         pending_status_ff <= i2cmts_pkg::ST_OK;
         wait_ticks_ff     <= 16'd0;
      end else if (advance) begin
         phase_ff          <= phase_in;
         slave_address_ff  <= slave_address_in;
         direction_read_ff <= direction_read_in;
         bytes_total_ff    <= bytes_total_in;
         bytes_done_ff     <= bytes_done_in;
         pending_status_ff <= pending_status_in;
         wait_ticks_ff     <= wait_ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_limit_ff <= i2cmts_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_limit_ff <= csr_wr_data;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/i2cmts_out_reg.sv
// Result register of the sequencer: holds one response beat until taken.
// Depends on i2cmts_pkg.
`default_nettype none
module i2cmts_out_reg (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire i2cmts_pkg::result_type result,
   output logic                        load_ready,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output i2cmts_pkg::result_type      out_result
);

   logic                   valid_ff;
   logic                   valid_in;
   i2cmts_pkg::result_type result_ff;

   assign load_ready = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/i2c_master_transaction_sequencer_top.sv
// A response beat is loaded into the result register as its request beat leaves
// the input register. Throughput: one request beat per cycle unless a full result
// register is held by rsp_tready; the phase logic in between is combinational.
// Reset (synchronous, active high) empties both registers, returns the phase
// to idle, clears the transaction state and sets timeout_limit to 50000.
// Top level of the I2C master transaction sequencer; uses i2cmts_pkg,
// i2cmts_in_stage, i2cmts_core, i2cmts_out_reg and the macros header.
`default_nettype none
`include "i2c_master_transaction_sequencer_top_macros.svh"
module i2c_master_transaction_sequencer_top #(
   parameter int unsigned MAX_TRANSFER = i2cmts_pkg::MAX_TRANSFER_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,   // timeout_limit
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // target_address[6:0], read_not_write[7], byte_count[15:8], write_byte[23:16],
   // engine_status[31:24], engine_data[39:32]
   input  wire logic [39:0] req_tdata,
   input  wire logic [2:0]  req_tuser,     // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // command_byte[7:0], need_write_data[8], read_valid[9], read_byte[17:10],
   // done_res[18], status[22:19], busy_res[23]
   output logic [23:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser      // command
);

   i2cmts_pkg::item_type   in_item;
   i2cmts_pkg::item_type   item;
   i2cmts_pkg::result_type result;
   i2cmts_pkg::result_type out_result;
   logic                   item_valid;
   logic                   load_ready;
   logic                   advance;

   assign in_item.operation      = req_tuser;
   assign in_item.target_address = req_tdata[6:0];
   assign in_item.read_not_write = req_tdata[7];
   assign in_item.byte_count     = req_tdata[15:8];
   assign in_item.write_byte     = req_tdata[23:16];
   assign in_item.engine_status  = req_tdata[31:24];
   assign in_item.engine_data    = req_tdata[39:32];

   assign advance = item_valid && load_ready;

   i2cmts_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cmts_core #(
      .MAX_TRANSFER (MAX_TRANSFER)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .item        (item),
      .result      (result)
   );

   i2cmts_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .load_ready (load_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   assign rsp_tuser = out_result.command;
   assign rsp_tdata = {out_result.busy_res, out_result.status, out_result.done_res,
                       out_result.read_byte, out_result.read_valid,
                       out_result.need_write_data, out_result.command_byte};

   `I2CMTS_ASSERT_NOW(a_done_not_busy, rsp_tvalid && out_result.done_res, !out_result.busy_res)
   `I2CMTS_ASSERT_NOW(a_status_only_done, rsp_tvalid && (|out_result.status), out_result.done_res)
   `I2CMTS_ASSERT_NOW(a_cmd_keeps_busy, rsp_tvalid && (|out_result.command), out_result.busy_res)
   `I2CMTS_ASSERT_NEXT(a_stalled_item_held, item_valid && !advance, item_valid)

endmodule
`default_nettype wire
